[sv/chacha_pkg.sv]
// Package with shared types, constants and functions for the ChaCha20 block.
package chacha_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [2:0] REG_START_COUNTER = 3'd6;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  // One queued request after classification by the front part.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        restart;
  } req_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter(input word_t a, input word_t b,
                                           input word_t c, input word_t d);
    word_t a1, b1, c1, d1;
    a1 = a + b; d1 = rotl(d ^ a1, 16);
    c1 = c + d1; b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    quarter = {a1, b1, c1, d1};
  endfunction

endpackage

[sv/chacha_front.sv]
// Front part: accepts requests, clamps the byte count and fills a short queue.
module chacha_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [63:0]         data_in,
  input  logic [3:0]          valid_bytes,
  input  logic                end_of_call,
  input  logic                restart,
  output logic                q_valid,
  input  logic                q_pop,
  output chacha_pkg::req_t    q_head
);
  import chacha_pkg::*;

  req_t        mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic [3:0]  cnt;

  always_comb begin
    cnt = valid_bytes;
    if (valid_bytes == 4'd0) cnt = 4'd1;
    else if (valid_bytes > 4'd8) cnt = 4'd8;
  end

  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (fill != 2'd0);
  assign q_head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= '{data: data_in, count: cnt, last: end_of_call,
                              restart: restart};
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

[sv/chacha_back.sv]
// Back part: runs the ChaCha20 rounds, holds the keystream and produces output.
module chacha_back #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [255:0]     key,
  input  logic [95:0]      nonce,
  input  logic [31:0]      start_counter,
  input  logic             q_valid,
  output logic             q_pop,
  input  chacha_pkg::req_t q_head,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      data_out,
  output logic [3:0]       out_bytes,
  output logic             out_last
);
  import chacha_pkg::*;

  localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);
  localparam logic [RW-1:0] ROUNDS = RW'(2 * DOUBLE_ROUNDS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_GEN  = 2'b10
  } fsm_t;

  fsm_t         fsm;
  state_t       work, init;
  logic [63:0]  ks [8];
  logic [31:0]  block_counter;
  logic [2:0]   word_position;
  logic         block_ready;
  logic         restart_taken;
  logic [RW-1:0] round;
  state_t       work_next;
  state_t       init_next;
  logic [31:0]  ctr_eff;
  logic         ready_eff;
  logic         restart_pending;
  logic         out_free;
  logic [63:0]  mask;

  // A restart request reloads the counter once; the flag marks that its block was made.
  assign restart_pending = q_head.restart && !restart_taken;
  assign out_free = !out_valid || !out_stall;
  assign ctr_eff = restart_pending ? start_counter : block_counter;
  assign ready_eff = block_ready && !restart_pending;
  assign q_pop = (fsm == S_IDLE) && q_valid && ready_eff && out_free;

  always_comb begin
    init_next[0] = SIGMA0; init_next[1] = SIGMA1;
    init_next[2] = SIGMA2; init_next[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init_next[4 + i] = key[32 * i +: 32];
    init_next[12] = ctr_eff;
    init_next[13] = nonce[31:0];
    init_next[14] = nonce[63:32];
    init_next[15] = nonce[95:64];
  end

  always_comb begin
    work_next = work;
    if (!round[0]) begin
      for (int i = 0; i < 4; i++)
        {work_next[i], work_next[4 + i], work_next[8 + i], work_next[12 + i]} =
          quarter(work[i], work[4 + i], work[8 + i], work[12 + i]);
    end else begin
      for (int i = 0; i < 4; i++)
        {work_next[i], work_next[4 + ((i + 1) % 4)], work_next[8 + ((i + 2) % 4)],
         work_next[12 + ((i + 3) % 4)]} =
          quarter(work[i], work[4 + ((i + 1) % 4)], work[8 + ((i + 2) % 4)],
                  work[12 + ((i + 3) % 4)]);
    end
  end

  always_comb begin
    mask = '1;
    if (q_head.count != 4'd8) mask = (64'd1 << {q_head.count, 3'b000}) - 64'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
      block_counter <= 32'd0;
      word_position <= 3'd0;
      block_ready <= 1'b0;
      restart_taken <= 1'b0;
      out_valid <= 1'b0;
      round <= '0;
    end else begin
      out_valid <= q_pop || (out_valid && out_stall);
      case (fsm)
        S_IDLE: begin
          if (q_valid && !ready_eff) begin
            init <= init_next;
            work <= init_next;
            block_counter <= ctr_eff + 32'd1;
            restart_taken <= q_head.restart;
            round <= '0;
            fsm <= S_GEN;
          end else if (q_pop) begin
            data_out <= (q_head.data ^ ks[word_position]) & mask;
            out_bytes <= q_head.count;
            out_last <= q_head.last;
            restart_taken <= 1'b0;
            word_position <= (word_position == 3'd7 || q_head.last) ? 3'd0 :
                             word_position + 3'd1;
            if (word_position == 3'd7 || q_head.last) begin
              block_ready <= 1'b0;
            end
          end
        end
        S_GEN: begin
          if (round == ROUNDS) begin
            for (int i = 0; i < 8; i++)
              ks[i] <= {work[2 * i + 1] + init[2 * i + 1], work[2 * i] + init[2 * i]};
            block_ready <= 1'b1;
            word_position <= 3'd0;
            fsm <= S_IDLE;
          end else begin
            work <= work_next;
            round <= round + RW'(1);
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/chacha20_stream_cipher.sv]
// Top level of the ChaCha20 stream cipher: configuration registers, front and back parts.
// Each word passes through the front queue and the output register of the back part; a new
// keystream block is generated first when none is held, one round per cycle in the back part.
// Throughput: one word per cycle within a block while the output is not stalled; words wait
// while a new block of eight words is generated.
// Reset clears the queue, the counter and the block state; the keystream is refilled on use.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_in,
  input  logic [3:0]  valid_bytes,
  input  logic        end_of_call,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_out,
  output logic [3:0]  out_bytes,
  output logic        out_last
);
  import chacha_pkg::*;

  logic [255:0] key;
  logic [95:0]  nonce;
  logic [31:0]  start_counter;
  logic         q_valid, q_pop;
  req_t         q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      nonce <= '0;
      start_counter <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key[63:0] <= cfg_data;
        REG_KEY1: key[127:64] <= cfg_data;
        REG_KEY2: key[191:128] <= cfg_data;
        REG_KEY3: key[255:192] <= cfg_data;
        REG_NONCE_LOW: nonce[63:0] <= cfg_data;
        REG_NONCE_HIGH: nonce[95:64] <= cfg_data[31:0];
        REG_START_COUNTER: start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  chacha_front u_front (
    .clk, .rst, .in_valid, .in_stall, .data_in, .valid_bytes, .end_of_call,
    .restart, .q_valid, .q_pop, .q_head
  );

  chacha_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
    .clk, .rst, .key, .nonce, .start_counter, .q_valid, .q_pop, .q_head,
    .out_valid, .out_stall, .data_out, .out_bytes, .out_last
  );
endmodule

[sim/tb_chacha20_stream_cipher.sv]
// Testbench for the ChaCha20 stream cipher: random and directed requests checked against a predictor.
module tb_chacha20_stream_cipher;
  import chacha_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        restart;
  } word_req_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } cipher_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_KEY0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] data_in = '0;
  logic [3:0]  valid_bytes = 4'd8;
  logic        end_of_call = 1'b0;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] data_out;
  logic [3:0]  out_bytes;
  logic        out_last;

  chacha20_stream_cipher dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [63:0] key_reg [4];
  logic [63:0] nonce_lo_reg;
  logic [31:0] nonce_hi_reg;
  logic [31:0] start_ctr_reg;
  logic [63:0] ks_words [8];
  logic [31:0] blk_ctr;
  logic [2:0]  word_pos;
  logic        have_block;

  word_req_t    pending_words[$];
  cipher_word_t expected_words[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  int words_checked = 0;
  int blocks_made = 0;
  bit done = 0;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void mix(ref logic [31:0] x[16], input int a, b, c, d);
    x[a] += x[b]; x[d] = rol32(x[d] ^ x[a], 16);
    x[c] += x[d]; x[b] = rol32(x[b] ^ x[c], 12);
    x[a] += x[b]; x[d] = rol32(x[d] ^ x[a], 8);
    x[c] += x[d]; x[b] = rol32(x[b] ^ x[c], 7);
  endfunction

  function automatic void generate_keystream();
    logic [31:0] init [16];
    logic [31:0] w [16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_reg[i][31:0];
      init[5 + 2 * i] = key_reg[i][63:32];
    end
    init[12] = blk_ctr;
    init[13] = nonce_lo_reg[31:0];
    init[14] = nonce_lo_reg[63:32];
    init[15] = nonce_hi_reg;
    w = init;
    for (int r = 0; r < 10; r++) begin
      mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
      mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
      mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
      mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) w[i] += init[i];
    for (int i = 0; i < 8; i++) ks_words[i] = {w[2 * i + 1], w[2 * i]};
    blk_ctr++;
    have_block = 1'b1;
    word_pos = '0;
    blocks_made++;
  endfunction

  function automatic cipher_word_t encrypt_word(word_req_t r);
    cipher_word_t c;
    logic [3:0] n;
    logic [63:0] mask;
    n = (r.count == 0) ? 4'd1 : (r.count > 8) ? 4'd8 : r.count;
    if (r.restart) begin
      blk_ctr = start_ctr_reg;
      have_block = 1'b0;
      word_pos = '0;
    end
    if (!have_block) generate_keystream();
    mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 1);
    c.data = (r.data ^ ks_words[word_pos]) & mask;
    c.count = n;
    c.last = r.last;
    word_pos++;
    if (word_pos == 0) have_block = 1'b0;
    if (r.last) begin
      have_block = 1'b0;
      word_pos = '0;
    end
    return c;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[idx] = val;
      REG_NONCE_LOW: nonce_lo_reg = val;
      REG_NONCE_HIGH: nonce_hi_reg = val[31:0];
      REG_START_COUNTER: start_ctr_reg = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid && expected_words.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic push_word(logic [63:0] d, logic [3:0] n, logic l, logic rs);
    word_req_t r;
    r.data = d; r.count = n; r.last = l; r.restart = rs;
    pending_words.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_phase(int nwords);
    int sent;
    int len;
    sent = 0;
    while (sent < nwords) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          push_word(rand64(), (i == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8,
                    i == len - 1, i == 0 && $urandom_range(0, 3) == 0);
      end
      sent += len;
    end
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_words.push_back(encrypt_word('{data_in, valid_bytes,
                                                             end_of_call, restart}));
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        word_req_t r;
        r = pending_words.pop_front();
        in_valid <= 1'b1;
        data_in <= r.data;
        valid_bytes <= r.count;
        end_of_call <= r.last;
        restart <= r.restart;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h", data_out);
          errors++;
        end else begin
          cipher_word_t e;
          e = expected_words.pop_front();
          if (data_out !== e.data) begin
            $error("data_out expected %h actual %h", e.data, data_out);
            errors++;
          end
          if (out_bytes !== e.count) begin
            $error("out_bytes expected %0d actual %0d", e.count, out_bytes);
            errors++;
          end
          if (out_last !== e.last) begin
            $error("out_last expected %0d actual %0d", e.last, out_last);
            errors++;
          end
          words_checked++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(0, 99) < recv_idle_pct;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || done || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("chacha20_stream_cipher test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce_lo_reg = '0; nonce_hi_reg = '0; start_ctr_reg = '0;
    blk_ctr = '0; word_pos = '0; have_block = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // RFC 7539 section 2.4.2 style setting, then directed words.
    write_reg(REG_KEY0, 64'h0706050403020100);
    write_reg(REG_KEY1, 64'h0f0e0d0c0b0a0908);
    write_reg(REG_KEY2, 64'h1716151413121110);
    write_reg(REG_KEY3, 64'h1f1e1d1c1b1a1918);
    write_reg(REG_NONCE_LOW, 64'h4a00000000000000);
    write_reg(REG_NONCE_HIGH, 64'h0);
    write_reg(REG_START_COUNTER, 64'h1);
    push_word(64'h0, 4'd8, 1'b0, 1'b1);
    push_word('1, 4'd8, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) push_word(rand64(), 4'd8, 1'b0, 1'b0);
    push_word(rand64(), 4'd0, 1'b0, 1'b0);
    push_word(rand64(), 4'd15, 1'b0, 1'b0);
    push_word(rand64(), 4'd9, 1'b0, 1'b0);
    push_word(rand64(), 4'd3, 1'b1, 1'b0);
    push_word(rand64(), 4'd1, 1'b1, 1'b1);
    push_word(rand64(), 4'd7, 1'b0, 1'b1);
    push_word(rand64(), 4'd8, 1'b1, 1'b0);
    drain();

    // Counter wrap and all-ones registers.
    for (int i = 0; i < 4; i++) write_reg(3'(i), '1);
    write_reg(REG_NONCE_LOW, '1);
    write_reg(REG_NONCE_HIGH, '1);
    write_reg(REG_START_COUNTER, 64'hffff_ffff);
    for (int i = 0; i < 20; i++) push_word(rand64(), 4'd8, 1'b0, i == 0);
    drain();

    send_idle_pct = 29; recv_idle_pct = 65;
    for (int i = 0; i < 4; i++) write_reg(3'(i), rand64());
    write_reg(REG_NONCE_LOW, rand64());
    write_reg(REG_NONCE_HIGH, rand64());
    write_reg(REG_START_COUNTER, rand64());
    write_reg(3'd7, rand64());
    random_phase(350);
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_off = 300;
    random_phase(60);
    drain();

    send_idle_pct = 65; recv_idle_pct = 29;
    write_reg(REG_START_COUNTER, 64'h0);
    write_reg(REG_KEY2, rand64());
    random_phase(300);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_NONCE_LOW, rand64());
    random_phase(350);
    drain();
    done = 1;

    $display("Checked %0d cipher words over %0d keystream blocks, several key settings,",
             words_checked, blocks_made);
    $display("counter wrap, partial words, restarts, long stalls and drain pauses.");
    if (errors == 0)
      $display("chacha20_stream_cipher test passed");
    else
      $display("chacha20_stream_cipher test failed");
    $finish;
  end
endmodule

[chacha20_stream_cipher.f]
sv/chacha_pkg.sv
sv/chacha_front.sv
sv/chacha_back.sv
sv/chacha20_stream_cipher.sv
sim/tb_chacha20_stream_cipher.sv
